### rtl/core/dtte_pkg.sv
// Shared types, constants and lookup tables for the date-time text converter.
// Depends on nothing; used by datetime_text_to_epoch.
`default_nettype none

package dtte_pkg;

   // Sequencer states, one-hot.
   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_DAYS  = 7'b0000010,
      ST_DSUM  = 7'b0000100,
      ST_SCALE = 7'b0001000,
      ST_HOUR  = 7'b0010000,
      ST_MIN   = 7'b0100000,
      ST_FRAC  = 7'b1000000
   } seq_state_type;

   // Field slots, in the order the numbers fill them.
   localparam logic [2:0] FIELD_YEAR   = 3'd0;
   localparam logic [2:0] FIELD_MONTH  = 3'd1;
   localparam logic [2:0] FIELD_DAY    = 3'd2;
   localparam logic [2:0] FIELD_HOUR   = 3'd3;
   localparam logic [2:0] FIELD_MINUTE = 3'd4;
   localparam logic [2:0] FIELD_SECOND = 3'd5;
   localparam logic [2:0] FIELD_FRAC   = 3'd6;
   localparam logic [2:0] FIELD_DONE   = 3'd7;
   localparam logic [2:0] FIELDS_NEEDED = 3'd5;

   localparam logic [29:0] VALUE_CAP  = 30'd999999999;
   localparam logic [29:0] YEAR_MIN   = 30'd1900;
   localparam logic [29:0] YEAR_MAX   = 30'd2100;
   localparam logic [29:0] MONTH_MAX  = 30'd12;
   localparam logic [29:0] DAY_MAX    = 30'd31;
   localparam logic [29:0] HOUR_MAX   = 30'd23;
   localparam logic [29:0] MINSEC_MAX = 30'd59;
   localparam logic [3:0]  FRAC_DIGITS = 4'd9;
   localparam logic [3:0]  COUNT_CAP   = 4'd15;

   // Day count is 365*Z + Z/4 - Z/100 + Z/400 + day-of-year - DAY_BIAS,
   // with Z the March-based year minus 1600.
   localparam logic [8:0]  YEAR_BASE = 9'd300;   // 1900 - 1600
   localparam logic [33:0] DAY_BIAS  = 34'd135080;
   localparam logic [29:0] DAYS_PER_YEAR = 30'd365;
   localparam logic [29:0] SECS_PER_DAY  = 30'd86400;
   localparam logic [29:0] SECS_PER_HOUR = 30'd3600;
   localparam logic [29:0] SECS_PER_MIN  = 30'd60;

   // Days from March 1 to the first of the given month.
   function automatic logic [8:0] month_doy(input logic [3:0] month);
      logic [8:0] doy;
      unique case (month)
         4'd1:    doy = 9'd306;
         4'd2:    doy = 9'd337;
         4'd3:    doy = 9'd0;
         4'd4:    doy = 9'd31;
         4'd5:    doy = 9'd61;
         4'd6:    doy = 9'd92;
         4'd7:    doy = 9'd122;
         4'd8:    doy = 9'd153;
         4'd9:    doy = 9'd184;
         4'd10:   doy = 9'd214;
         4'd11:   doy = 9'd245;
         4'd12:   doy = 9'd275;
         default: doy = 9'd0;
      endcase
      return doy;
   endfunction

   // Scale that turns an n-digit fraction into nanoseconds.
   function automatic logic [29:0] frac_scale(input logic [3:0] digits);
      logic [29:0] scale;
      unique case (digits)
         4'd0:    scale = 30'd1000000000;
         4'd1:    scale = 30'd100000000;
         4'd2:    scale = 30'd10000000;
         4'd3:    scale = 30'd1000000;
         4'd4:    scale = 30'd100000;
         4'd5:    scale = 30'd10000;
         4'd6:    scale = 30'd1000;
         4'd7:    scale = 30'd100;
         4'd8:    scale = 30'd10;
         default: scale = 30'd1;
      endcase
      return scale;
   endfunction

endpackage

`default_nettype wire

### rtl/core/datetime_text_to_epoch.sv
// Date-time text to UTC epoch seconds and nanoseconds converter, top level.
// Depends on dtte_pkg for state codes, field limits and lookup tables.
// Timing: a byte without tlast is taken while idle; the item with tlast
// starts a conversion through the states DAYS, DSUM, SCALE, HOUR, MIN and
// FRAC, and its result is registered as FRAC ends, later if the previous
// result still sits unaccepted in the output register. Throughput: one byte
// per cycle inside a text; no byte is taken while the single shared multiply-accumulate unit converts a text.
// Reset: synchronous, active high; clears the sequencer, the parser state and the output valid.
`default_nettype none

module datetime_text_to_epoch
   import dtte_pkg::*;
#(
   parameter int MAX_CHARS = 32
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // [7:0] char_code
   input  wire         req_tlast,   // last
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [63:0] rsp_tdata,   // [32:0] epoch_seconds, [62:33] fraction_ns, [63] zero
   output logic        rsp_tuser    // [0] bad_text
);

   // Byte counter holds up to MAX_CHARS-1, the number of bytes kept.
   localparam int CNT_W = $clog2(MAX_CHARS);
   localparam logic [CNT_W-1:0] BYTE_LIMIT = CNT_W'(MAX_CHARS - 1);

   // Parser state.
   logic             in_number_ff,   in_number_in;
   logic [2:0]       field_index_ff, field_index_in;
   logic [29:0]      digit_value_ff, digit_value_in;
   logic [3:0]       digit_count_ff, digit_count_in;
   logic [7:0]       year_offset_ff, year_offset_in;
   logic [3:0]       month_ff,       month_in;
   logic [4:0]       day_ff,         day_in;
   logic [4:0]       hour_ff,        hour_in;
   logic [5:0]       minute_ff,      minute_in;
   logic [5:0]       second_ff,      second_in;
   logic [29:0]      frac_ff,        frac_in;
   logic [3:0]       frac_digits_ff, frac_digits_in;
   logic             range_fault_ff, range_fault_in;
   logic [CNT_W-1:0] byte_count_ff,  byte_count_in;
   logic             text_ended_ff,  text_ended_in;

   // Sequencer and the shared multiply-accumulate unit.
   seq_state_type    state_ff, state_in;
   logic [33:0]      acc_ff, acc_in;
   logic [33:0]      prod_ff, prod_in;
   logic [30:0]      op_a;
   logic [29:0]      op_b;
   logic [61:0]      prod_full;

   // Output register.
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_bad_ff,   rsp_bad_in;
   logic [32:0]      rsp_secs_ff,  rsp_secs_in;
   logic [29:0]      rsp_ns_ff,    rsp_ns_in;

   // Byte decode.
   logic             accept;
   logic             is_digit;
   logic [3:0]       digit;
   logic             active;
   logic             room;
   logic             take;
   logic             end_now;
   logic             do_close;
   logic [33:0]      times_ten;
   logic [29:0]      val_after;
   logic [3:0]       cnt_after;
   logic             in_after;

   // Day-count terms.
   logic             early_month;
   logic [8:0]       year_z;
   logic [14:0]      year_z41;
   logic [33:0]      day_bias_sum;
   logic             bad_now;
   logic             out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign is_digit  = (req_tdata >= 8'h30) && (req_tdata <= 8'h39);
   assign digit     = req_tdata[3:0];
   assign active    = !text_ended_ff;
   assign room      = (byte_count_ff < BYTE_LIMIT);
   assign take      = active && room && is_digit;
   // A zero byte, or the byte after the kept window, ends the text.
   assign end_now   = active && (!room || (req_tdata == 8'h00));
   assign times_ten = {1'b0, digit_value_ff, 3'b000} + {3'b000, digit_value_ff, 1'b0}
                      + {30'd0, digit};

   // Value of the open number after this byte, before any close.
   always_comb begin
      val_after = digit_value_ff;
      cnt_after = digit_count_ff;
      in_after  = in_number_ff;
      if (take) begin
         in_after = 1'b1;
         if (field_index_ff == FIELD_FRAC) begin
            // Fraction keeps only its first nine digits.
            if (digit_count_ff < FRAC_DIGITS) begin
               val_after = times_ten[29:0];
               cnt_after = digit_count_ff + 4'd1;
            end
         end else begin
            val_after = (times_ten > {4'd0, VALUE_CAP}) ? VALUE_CAP : times_ten[29:0];
            if (digit_count_ff < COUNT_CAP) begin
               cnt_after = digit_count_ff + 4'd1;
            end
         end
      end
   end

   // Any byte in the text that is not a digit, or that lies past the kept window,
   // closes the number, and so does the final byte of the item.
   assign do_close = in_after && ((active && !take) || req_tlast);

   // Day count terms, taken from the stored fields during the sequence.
   assign early_month  = (month_ff <= 4'd2);
   assign year_z       = YEAR_BASE + {1'b0, year_offset_ff} - {8'd0, early_month};
   assign year_z41     = {1'b0, year_z, 5'b00000} + {3'b000, year_z, 3'b000}
                         + {6'd0, year_z};
   assign day_bias_sum = {27'd0, year_z[8:2]}
                         - {31'd0, year_z41[14:12]}
                         + {33'd0, (year_z >= 9'd400)}
                         + {25'd0, month_doy(month_ff)}
                         + {29'd0, day_ff}
                         - 34'd1
                         - DAY_BIAS;
   assign bad_now      = range_fault_ff || (field_index_ff < FIELDS_NEEDED);

   // Operand selection for the shared multiplier.
   always_comb begin
      op_a = 31'd0;
      op_b = 30'd0;
      unique case (state_ff)
         ST_DAYS: begin
            op_a = {22'd0, year_z};
            op_b = DAYS_PER_YEAR;
         end
         ST_SCALE: begin
            op_a = acc_ff[30:0];
            op_b = SECS_PER_DAY;
         end
         ST_HOUR: begin
            op_a = {26'd0, hour_ff};
            op_b = SECS_PER_HOUR;
         end
         ST_MIN: begin
            op_a = {25'd0, minute_ff};
            op_b = SECS_PER_MIN;
         end
         ST_FRAC: begin
            op_a = {1'b0, frac_ff};
            op_b = frac_scale(frac_digits_ff);
         end
         default: begin
            op_a = 31'd0;
            op_b = 30'd0;
         end
      endcase
   end

   assign prod_full = $signed(op_a) * $signed({1'b0, op_b});

   always_comb begin
      in_number_in   = in_number_ff;
      field_index_in = field_index_ff;
      digit_value_in = digit_value_ff;
      digit_count_in = digit_count_ff;
      year_offset_in = year_offset_ff;
      month_in       = month_ff;
      day_in         = day_ff;
      hour_in        = hour_ff;
      minute_in      = minute_ff;
      second_in      = second_ff;
      frac_in        = frac_ff;
      frac_digits_in = frac_digits_ff;
      range_fault_in = range_fault_ff;
      byte_count_in  = byte_count_ff;
      text_ended_in  = text_ended_ff;
      state_in       = state_ff;
      acc_in         = acc_ff;
      prod_in        = prod_full[33:0];
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_bad_in     = rsp_bad_ff;
      rsp_secs_in    = rsp_secs_ff;
      rsp_ns_in      = rsp_ns_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               in_number_in   = in_after;
               digit_value_in = val_after;
               digit_count_in = cnt_after;
               if (active && room) begin
                  byte_count_in = byte_count_ff + CNT_W'(1);
               end
               if (end_now) begin
                  text_ended_in = 1'b1;
               end
               if (do_close) begin
                  // Store the finished number into its field after a range check.
                  case (field_index_ff)
                     FIELD_YEAR: begin
                        if (val_after < YEAR_MIN || val_after > YEAR_MAX) begin
                           range_fault_in = 1'b1;
                        end else begin
                           year_offset_in = 8'(val_after - YEAR_MIN);
                        end
                     end
                     FIELD_MONTH: begin
                        if (val_after < 30'd1 || val_after > MONTH_MAX) begin
                           range_fault_in = 1'b1;
                        end else begin
                           month_in = val_after[3:0];
                        end
                     end
                     FIELD_DAY: begin
                        if (val_after < 30'd1 || val_after > DAY_MAX) begin
                           range_fault_in = 1'b1;
                        end else begin
                           day_in = val_after[4:0];
                        end
                     end
                     FIELD_HOUR: begin
                        if (val_after > HOUR_MAX) begin
                           range_fault_in = 1'b1;
                        end else begin
                           hour_in = val_after[4:0];
                        end
                     end
                     FIELD_MINUTE: begin
                        if (val_after > MINSEC_MAX) begin
                           range_fault_in = 1'b1;
                        end else begin
                           minute_in = val_after[5:0];
                        end
                     end
                     FIELD_SECOND: begin
                        if (val_after > MINSEC_MAX) begin
                           range_fault_in = 1'b1;
                        end else begin
                           second_in = val_after[5:0];
                        end
                     end
                     FIELD_FRAC: begin
                        // Scaled to nanoseconds later by the shared unit.
                        frac_in        = val_after;
                        frac_digits_in = cnt_after;
                     end
                     default: begin
                     end
                  endcase
                  if (field_index_ff != FIELD_DONE) begin
                     field_index_in = field_index_ff + 3'd1;
                  end
                  in_number_in   = 1'b0;
                  digit_value_in = 30'd0;
                  digit_count_in = 4'd0;
               end
               if (req_tlast) begin
                  state_in = ST_DAYS;
               end
            end
         end
         ST_DAYS: begin
            acc_in   = day_bias_sum;
            state_in = ST_DSUM;
         end
         ST_DSUM: begin
            acc_in   = acc_ff + prod_ff;          // day count since 1970
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            acc_in   = {28'd0, second_ff};
            state_in = ST_HOUR;
         end
         ST_HOUR: begin
            acc_in   = acc_ff + prod_ff;
            state_in = ST_MIN;
         end
         ST_MIN: begin
            acc_in   = acc_ff + prod_ff;
            state_in = ST_FRAC;
         end
         ST_FRAC: begin
            // The last product (minutes) is folded in while the fraction
            // product is formed; the result leaves once the output is free.
            prod_in = prod_ff;
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_bad_in     = bad_now;
               rsp_secs_in    = bad_now ? 33'd0 : 33'(acc_ff + prod_ff);
               rsp_ns_in      = bad_now ? 30'd0 : prod_full[29:0];
               in_number_in   = 1'b0;
               field_index_in = FIELD_YEAR;
               digit_value_in = 30'd0;
               digit_count_in = 4'd0;
               year_offset_in = 8'd0;
               month_in       = 4'd0;
               day_in         = 5'd0;
               hour_in        = 5'd0;
               minute_in      = 6'd0;
               second_in      = 6'd0;
               frac_in        = 30'd0;
               frac_digits_in = 4'd0;
               range_fault_in = 1'b0;
               byte_count_in  = '0;
               text_ended_in  = 1'b0;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         in_number_ff   <= 1'b0;
         field_index_ff <= FIELD_YEAR;
         digit_value_ff <= 30'd0;
         digit_count_ff <= 4'd0;
         year_offset_ff <= 8'd0;
         month_ff       <= 4'd0;
         day_ff         <= 5'd0;
         hour_ff        <= 5'd0;
         minute_ff      <= 6'd0;
         second_ff      <= 6'd0;
         frac_ff        <= 30'd0;
         frac_digits_ff <= 4'd0;
         range_fault_ff <= 1'b0;
         byte_count_ff  <= '0;
         text_ended_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         in_number_ff   <= in_number_in;
         field_index_ff <= field_index_in;
         digit_value_ff <= digit_value_in;
         digit_count_ff <= digit_count_in;
         year_offset_ff <= year_offset_in;
         month_ff       <= month_in;
         day_ff         <= day_in;
         hour_ff        <= hour_in;
         minute_ff      <= minute_in;
         second_ff      <= second_in;
         frac_ff        <= frac_in;
         frac_digits_ff <= frac_digits_in;
         range_fault_ff <= range_fault_in;
         byte_count_ff  <= byte_count_in;
         text_ended_ff  <= text_ended_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Datapath registers need no reset.
   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      prod_ff     <= prod_in;
      rsp_bad_ff  <= rsp_bad_in;
      rsp_secs_ff <= rsp_secs_in;
      rsp_ns_ff   <= rsp_ns_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ns_ff, rsp_secs_ff};
   assign rsp_tuser  = rsp_bad_ff;

endmodule

`default_nettype wire
